/* design/tpf_pkg.sv */
package tpf_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int INDEX_BITS     = 16;
  localparam int WIDTH_BITS     = 10;

  // config port sized for the widest register
  localparam int CFG_DATA_BITS  = (SAMPLE_BITS > INDEX_BITS) ?
                                  ((SAMPLE_BITS > WIDTH_BITS) ? SAMPLE_BITS : WIDTH_BITS) :
                                  ((INDEX_BITS > WIDTH_BITS) ? INDEX_BITS : WIDTH_BITS);
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_LEVEL  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPECTED_PEAKS = 2'd2;

  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // result queue
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                          kind;
    logic [INDEX_BITS-1:0]         peak_index;
    logic signed [SAMPLE_BITS-1:0] peak_value;
    logic [INDEX_BITS-1:0]         peak_total;
    logic                          count_status;
    logic                          final_result;
  } result_t;

endpackage

/* design/tpf_sample_if.sv */
interface tpf_sample_if;
  import tpf_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_record;

  modport source (output valid, output sample, output end_of_record, input ready);
  modport sink   (input valid, input sample, input end_of_record, output ready);
endinterface

/* design/tpf_result_if.sv */
interface tpf_result_if;
  import tpf_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [INDEX_BITS-1:0]         peak_index;
  logic signed [SAMPLE_BITS-1:0] peak_value;
  logic [INDEX_BITS-1:0]         peak_total;
  logic                          count_status;
  logic                          final_result;

  modport source (output valid, output kind, output peak_index, output peak_value,
                  output peak_total, output count_status, output final_result,
                  input ready);
  modport sink   (input valid, input kind, input peak_index, input peak_value,
                  input peak_total, input count_status, input final_result,
                  output ready);
endinterface

/* design/triggered_peak_finder_core.sv */
// results of a sample are written into the result queue at its transfer
// throughput: one sample per cycle unless held off; a sample causing two results
// (peak and summary) has them read out in turn, absorbed by a four-entry result queue
// input is held off while more than two results are queued
// reset (synchronous, active high) clears the window state, the peak count,
// the result queue and loads the register defaults (level 0, width 16, check off)
module triggered_peak_finder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tpf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tpf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  tpf_sample_if.sink                          samples,
  tpf_result_if.source                        reports
);
  import tpf_pkg::*;

  // configuration registers
  logic signed [SAMPLE_BITS-1:0] trigger_level;
  logic [WIDTH_BITS-1:0]         pulse_width;
  logic [INDEX_BITS-1:0]         expected_peaks;

  // window tracking state
  logic [INDEX_BITS-1:0]         sample_position;
  logic                          window_active;
  logic [WIDTH_BITS-1:0]         window_left;
  logic signed [SAMPLE_BITS-1:0] best_value;
  logic [INDEX_BITS-1:0]         best_position;
  logic [INDEX_BITS-1:0]         found_count;

  // result queue
  result_t                       queue [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0]     wr_ptr;
  logic [QUEUE_PTR_BITS-1:0]     rd_ptr;
  logic [QUEUE_CNT_BITS-1:0]     count;

  // per-sample datapath
  logic                          in_xfer;
  logic                          out_xfer;
  logic [WIDTH_BITS-1:0]         width_eff;
  logic                          opens;
  logic                          in_window;
  logic signed [SAMPLE_BITS-1:0] best_value_next;
  logic [INDEX_BITS-1:0]         best_position_next;
  logic [WIDTH_BITS-1:0]         left_dec;
  logic                          closes;
  logic                          still_open;
  logic                          record_closes;
  logic                          peak_out;
  logic [INDEX_BITS-1:0]         count_closed;
  logic [INDEX_BITS-1:0]         count_final;
  logic                          mismatch;
  result_t                       peak_res;
  result_t                       summary_res;
  result_t                       first_res;
  logic [1:0]                    push_n;

  assign in_xfer  = samples.valid && samples.ready;
  assign out_xfer = reports.valid && reports.ready;

  // room for the worst case of two results per sample
  assign samples.ready = (count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

  // a width of zero behaves as one
  assign width_eff = (pulse_width == '0) ? WIDTH_BITS'(1) : pulse_width;

  always_comb begin
    opens              = !window_active && (samples.sample <= trigger_level);
    in_window          = window_active || opens;
    best_value_next    = best_value;
    best_position_next = best_position;
    left_dec           = window_left - WIDTH_BITS'(1);
    if (opens) begin
      best_value_next    = samples.sample;
      best_position_next = sample_position;
      left_dec           = width_eff - WIDTH_BITS'(1);
    end else if (window_active && (samples.sample < best_value)) begin
      // first strict minimum wins, equal samples keep the earlier one
      best_value_next    = samples.sample;
      best_position_next = sample_position;
    end
    closes        = in_window && (left_dec == '0);
    still_open    = in_window && !closes;
    // record end truncates an open window into a report of its own
    record_closes = samples.end_of_record && still_open;
    peak_out      = closes || record_closes;

    // saturating peak count
    count_closed = (peak_out && (found_count != '1)) ?
                   found_count + INDEX_BITS'(1) : found_count;
    count_final  = count_closed;
    mismatch     = (expected_peaks != '0) && (count_final != expected_peaks);

    peak_res              = '0;
    peak_res.kind         = KIND_PEAK;
    peak_res.peak_index   = best_position_next;
    peak_res.peak_value   = best_value_next;
    peak_res.final_result = !samples.end_of_record;

    summary_res              = '0;
    summary_res.kind         = KIND_SUMMARY;
    summary_res.peak_total   = count_final;
    summary_res.count_status = mismatch;
    summary_res.final_result = 1'b1;

    first_res = peak_out ? peak_res : summary_res;
    push_n    = 2'(peak_out) + 2'(samples.end_of_record);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level  <= '0;
      pulse_width    <= WIDTH_BITS'(16);
      expected_peaks <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_LEVEL:  trigger_level  <= cfg_data[SAMPLE_BITS-1:0];
        REG_PULSE_WIDTH:    pulse_width    <= cfg_data[WIDTH_BITS-1:0];
        REG_EXPECTED_PEAKS: expected_peaks <= cfg_data[INDEX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // window state update on every sample transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      window_active   <= 1'b0;
      window_left     <= '0;
      best_value      <= '0;
      best_position   <= '0;
      found_count     <= '0;
    end else if (in_xfer) begin
      best_value    <= best_value_next;
      best_position <= best_position_next;
      if (samples.end_of_record) begin
        // next sample starts a fresh record
        sample_position <= '0;
        window_active   <= 1'b0;
        window_left     <= '0;
        found_count     <= '0;
      end else begin
        sample_position <= sample_position + INDEX_BITS'(1);
        window_active   <= still_open;
        window_left     <= still_open ? left_dec : '0;
        found_count     <= count_closed;
      end
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_xfer && (push_n != 2'd0)) begin
      queue[wr_ptr] <= first_res;
      if (push_n == 2'd2) begin
        queue[wr_ptr + QUEUE_PTR_BITS'(1)] <= summary_res;
      end
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(push_n);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      count <= count + (in_xfer ? QUEUE_CNT_BITS'(push_n) : '0)
                     - QUEUE_CNT_BITS'(out_xfer);
    end
  end

  assign reports.valid        = (count != '0);
  assign reports.kind         = queue[rd_ptr].kind;
  assign reports.peak_index   = queue[rd_ptr].peak_index;
  assign reports.peak_value   = queue[rd_ptr].peak_value;
  assign reports.peak_total   = queue[rd_ptr].peak_total;
  assign reports.count_status = queue[rd_ptr].count_status;
  assign reports.final_result = queue[rd_ptr].final_result;

`ifndef SYNTHESIS
  // queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // a transfer never pushes past the free space
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> (4'(count) + 4'(push_n) <= 4'(QUEUE_DEPTH)))
    else $error("result push beyond queue space");

  // an open window always has samples left to come
  assert property (@(posedge clk) disable iff (rst)
    window_active |-> (window_left != '0))
    else $error("open window with no samples left");

  // record end leaves a clean record state
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && samples.end_of_record) |=>
      (sample_position == '0) && !window_active && (found_count == '0))
    else $error("record state not cleared at record end");

  // every record end queues a summary, so the queue cannot be empty next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && samples.end_of_record) |=> (count != '0))
    else $error("summary missing after record end");
`endif

endmodule
